// ===== hdl/rsl_pkg.sv =====
// Shared types and constants for the run-slice line rasterizer.
// No dependencies; every other file imports this package.
`default_nettype none

package rsl_pkg;

  // Coordinate width and the width of run counts (dmax+1 reaches 2**CoordBits)
  localparam int CoordBits = 6;
  localparam int DivW      = CoordBits + 1;
  localparam int DivSteps  = DivW;
  localparam int DivCntW   = $clog2(DivSteps);

  typedef logic [CoordBits-1:0] coord_t;
  typedef logic [DivW-1:0]      cnt_t;

  // One input request: the two endpoints of a segment
  typedef struct packed {
    coord_t x_first;
    coord_t y_first;
    coord_t x_second;
    coord_t y_second;
  } in_item_t;

  // One result: a pixel and its end-of-line mark
  typedef struct packed {
    coord_t pixel_x;
    coord_t pixel_y;
    logic   last_pixel;
  } out_item_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;      // capture endpoints, ordered by x
    logic setup;     // form deltas, seed divider
    logic div_step;  // one restoring divide step
    logic run_init;  // length of the first run
    logic emit;      // load output register, advance one pixel
  } rsl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic last;      // current pixel is the end point
  } rsl_status_t;

endpackage

`default_nettype wire

// ===== hdl/run_slice_line_rasterizer.sv =====
// Top level of the run-slice line rasterizer: controller plus datapath.
// Depends on rsl_pkg, rsl_ctrl and rsl_datapath.
//
// Takes one request with two endpoints and emits the segment's pixels in
// order of non-decreasing x, one result per cycle while the consumer is ready,
// the final pixel (the end point) marked by last_pixel. A line of L pixels
// (L = max(|dx|,|dy|)+1, at most 64) passes through an accept state, a
// setup state, the restoring divider steps that form run length and
// remainder, a state to size the first run, then pixel emission. A new
// request is taken once the last pixel sits in the output register, even
// while that pixel still waits to be taken.
`default_nettype none

module run_slice_line_rasterizer import rsl_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire in_item_t  in_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output out_item_t      out_o
);

  rsl_cmd_t    cmd;
  rsl_status_t status;

  rsl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  rsl_datapath u_datapath (
    .clk_i    (clk_i),
    .in_i     (in_i),
    .cmd_i    (cmd),
    .status_o (status),
    .out_o    (out_o)
  );

`ifndef SYNTHESIS
  // Busy right after a request is taken
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("rasterizer ready in the cycle after accepting a request");

  // While idle, only a line's final pixel can be pending
  a_idle_holds_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o && out_valid_o |-> out_o.last_pixel)
    else $error("non-final pixel pending while idle");

  // A non-final pixel leaving means the line is still being drawn
  a_mid_line_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !out_o.last_pixel |-> !in_ready_o)
    else $error("idle before the final pixel was emitted");
`endif

endmodule

`default_nettype wire

// ===== hdl/rsl_datapath.sv =====
// Datapath of the run-slice line rasterizer: endpoint ordering, run length
// divider, run accumulator, pixel stepper and output register. Uses rsl_pkg.
`default_nettype none

module rsl_datapath import rsl_pkg::*; (
  input  wire logic        clk_i,
  input  wire in_item_t    in_i,
  input  wire rsl_cmd_t    cmd_i,
  output rsl_status_t      status_o,
  output out_item_t        out_o
);

  coord_t    px_q, py_q, xe_q, ye_q;
  coord_t    dmax_q, cnt_q;
  logic      horiz_q, yneg_q;
  cnt_t      nruns_q, dvd_q, rem_q, acc_q, len_q;
  out_item_t out_q;

  // Deltas from the ordered endpoints (px/py hold the start point here)
  logic   yneg;
  coord_t dx, ady, dmin, dmax;
  always_comb begin
    yneg = (ye_q < py_q);
    dx   = xe_q - px_q;
    ady  = yneg ? (py_q - ye_q) : (ye_q - py_q);
    dmin = (dx < ady) ? dx : ady;
    dmax = (dx < ady) ? ady : dx;
  end

  // Restoring divide step: dividend shifts out of dvd_q, quotient shifts in
  cnt_t trial;
  logic ge;
  always_comb begin
    trial = {rem_q[DivW-2:0], dvd_q[DivW-1]};
    ge    = (trial >= nruns_q);
  end

  // Next run: accumulator k*rem mod n, extra pixel on wrap
  cnt_t sum, nxt, len;
  logic wrap;
  always_comb begin
    sum  = acc_q + rem_q;
    wrap = (sum >= nruns_q);
    nxt  = wrap ? (sum - nruns_q) : sum;
    len  = dvd_q + {{(DivW-1){1'b0}}, wrap};
  end

  // Pixel stepping: major axis every pixel, minor axis at run end
  logic   run_end, x_inc, y_inc;
  coord_t py_step;
  always_comb begin
    run_end = (len_q == cnt_t'(1));
    x_inc   = horiz_q || run_end;
    y_inc   = !horiz_q || run_end;
    py_step = yneg_q ? (py_q - coord_t'(1)) : (py_q + coord_t'(1));
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      if (in_i.x_first < in_i.x_second) begin
        px_q <= in_i.x_first;
        py_q <= in_i.y_first;
        xe_q <= in_i.x_second;
        ye_q <= in_i.y_second;
      end else begin
        px_q <= in_i.x_second;
        py_q <= in_i.y_second;
        xe_q <= in_i.x_first;
        ye_q <= in_i.y_first;
      end
    end
    if (cmd_i.setup) begin
      yneg_q  <= yneg;
      horiz_q <= (dx > ady);
      dmax_q  <= dmax;
      nruns_q <= {1'b0, dmin} + cnt_t'(1);
      dvd_q   <= {1'b0, dmax} + cnt_t'(1);
      rem_q   <= '0;
      acc_q   <= '0;
      cnt_q   <= '0;
    end
    if (cmd_i.div_step) begin
      rem_q <= ge ? (trial - nruns_q) : trial;
      dvd_q <= {dvd_q[DivW-2:0], ge};
    end
    if (cmd_i.run_init) begin
      acc_q <= nxt;
      len_q <= len;
    end
    if (cmd_i.emit) begin
      out_q.pixel_x    <= px_q;
      out_q.pixel_y    <= py_q;
      out_q.last_pixel <= (cnt_q == dmax_q);
      cnt_q            <= cnt_q + coord_t'(1);
      if (x_inc) px_q <= px_q + coord_t'(1);
      if (y_inc) py_q <= py_step;
      if (run_end) begin
        acc_q <= nxt;
        len_q <= len;
      end else begin
        len_q <= len_q - cnt_t'(1);
      end
    end
  end

  assign status_o.last = (cnt_q == dmax_q);
  assign out_o         = out_q;

endmodule

`default_nettype wire

// ===== hdl/rsl_ctrl.sv =====
// Controller of the run-slice line rasterizer: sequences load, setup,
// divide, run start and pixel emission; owns output valid. Uses rsl_pkg.
`default_nettype none

module rsl_ctrl import rsl_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  input  wire rsl_status_t status_i,
  output rsl_cmd_t         cmd_o
);

  typedef enum logic [2:0] {
    StIdle,
    StSetup,
    StDiv,
    StRun0,
    StDraw
  } state_e;

  state_e             state_q, state_d;
  logic [DivCntW-1:0] div_cnt_q, div_cnt_d;
  logic               out_valid_q, out_valid_d;
  logic               emit;

  // Emit when the output register is free or being drained
  assign emit = (state_q == StDraw) && (!out_valid_q || out_ready_i);

  always_comb begin
    cmd_o          = '0;
    cmd_o.load     = (state_q == StIdle) && in_valid_i;
    cmd_o.setup    = (state_q == StSetup);
    cmd_o.div_step = (state_q == StDiv);
    cmd_o.run_init = (state_q == StRun0);
    cmd_o.emit     = emit;
  end

  // Next state, divide step counter and output valid
  always_comb begin
    state_d     = state_q;
    div_cnt_d   = div_cnt_q;
    out_valid_d = out_valid_q;
    if (out_ready_i) out_valid_d = 1'b0;
    if (emit) out_valid_d = 1'b1;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) state_d = StSetup;
      end
      StSetup: begin
        div_cnt_d = DivCntW'(DivSteps - 1);
        state_d   = StDiv;
      end
      StDiv: begin
        div_cnt_d = div_cnt_q - DivCntW'(1);
        if (div_cnt_q == '0) state_d = StRun0;
      end
      StRun0: begin
        state_d = StDraw;
      end
      StDraw: begin
        if (emit && status_i.last) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      div_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      div_cnt_q   <= div_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire
